### hw/rtl/window_metric_aggregator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the window metric aggregator
// Shared property wrappers used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef WINDOW_METRIC_AGGREGATOR_ASSERT_SVH
`define WINDOW_METRIC_AGGREGATOR_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define WMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define WMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/wma_pkg.sv
// ----------------------------------------------------------------------------
// Window metric aggregator package
// Types, widths and reset constants shared by the aggregator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wma_pkg;

  // Field widths fixed by the transaction format.
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned FLAGS_W     = 16;
  localparam int unsigned WLEN_W      = 16;
  localparam int unsigned MEM_SUM_W   = 32;

  // Defaults for the top-level parameters.
  localparam int unsigned EMA_FRACTION_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF       = 2;

  // Reset value of the window length register.
  localparam int unsigned WINDOW_LENGTH_RESET = 60;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;

  // Input transaction.
  typedef struct packed {
    logic [TIME_W-1:0]   sample_time;
    logic [SAMPLE_W-1:0] cpu_sample;
    logic [SAMPLE_W-1:0] mem_sample;
    logic [FLAGS_W-1:0]  cpu_state_bits;
    logic [FLAGS_W-1:0]  mem_state_bits;
  } in_t;

  // Output transaction.
  typedef struct packed {
    logic [TIME_W-1:0]   latest_time;
    logic [SAMPLE_W-1:0] cpu_smoothed;
    logic [SAMPLE_W-1:0] mem_mean;
    logic [FLAGS_W-1:0]  cpu_state_union;
    logic [FLAGS_W-1:0]  mem_state_union;
  } out_t;

  // Classified sample as it sits in the queue between front and back.
  typedef struct packed {
    in_t               data;
    logic              first;
    logic              last;
    logic [WLEN_W-1:0] count;
  } q_entry_t;

  // Status of a serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/window_metric_aggregator.sv
// ----------------------------------------------------------------------------
// Window metric aggregator
// Reduces each window of metric samples to one record: maximum timestamp,
// CPU EMA, mean memory usage and the OR of both flag words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o/in_data_i carries one sample per
//   transaction; output channel out_valid_o/out_stall_i/out_data_o carries
//   one record per completed window. The APB port holds the window length.
//   The back end takes each sample in two steps (pop with multiply, then
//   accumulate) and pops no new sample until the last is accumulated; the
//   two-entry queue lets the front keep accepting while the back is busy.
//   For the sample that closes a window the back then runs the serial mean
//   divider and loads the record into the output register.
//   A window length write recomputes the smoothing factor in a serial
//   divider; input is stalled after the write until the factor is loaded.
//   Reset empties the queue, clears all accumulators and the output valid
//   flag, loads a length of 60 and the matching smoothing factor.
//   While the receiver stalls the record is held; the back keeps consuming
//   samples until the next record is ready, then waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none

module window_metric_aggregator #(
  parameter int unsigned EMA_FRACTION_BITS = wma_pkg::EMA_FRACTION_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH       = wma_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire wma_pkg::in_t                     in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output wma_pkg::out_t                         out_data_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [wma_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [wma_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [wma_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);

  localparam int unsigned F        = EMA_FRACTION_BITS;
  localparam int unsigned LW       = wma_pkg::WLEN_W;
  localparam int unsigned ALPHA_W  = F + 1;
  localparam int unsigned ANUM_W   = F + 2;
  localparam int unsigned AlphaReset = (2 << F) / (wma_pkg::WINDOW_LENGTH_RESET + 1);

  logic [LW-1:0]      wlen_q, wlen_d;
  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic               alpha_pend_q, alpha_pend_d;
  logic               cfg_wr;
  logic [LW-1:0]      wr_len;
  logic [LW:0]        alpha_den;
  logic [ANUM_W-1:0]  alpha_quot;
  wma_pkg::div_stat_t alpha_stat;

  wma_pkg::q_entry_t  push_entry;
  wma_pkg::q_entry_t  head;
  logic               push;
  logic               q_full;
  logic               pop;
  logic               head_valid;

  // Configuration register, a single register so every write lands on it.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = wma_pkg::APB_DATA_W'(wlen_q);
  assign wr_len = pwdata[LW-1:0];

  // Divisor is the effective length plus one; a zero length counts as one.
  assign alpha_den = (wr_len == '0) ? (LW+1)'(2) : {1'b0, wr_len} + (LW+1)'(1);

  // Length and smoothing factor update. The quotient never exceeds 2^F.
  always_comb begin
    wlen_d       = wlen_q;
    alpha_d      = alpha_q;
    alpha_pend_d = alpha_pend_q;
    if (cfg_wr) begin
      wlen_d       = wr_len;
      alpha_pend_d = 1'b1;
    end else if (alpha_pend_q && alpha_stat.done) begin
      alpha_d      = alpha_quot[ALPHA_W-1:0];
      alpha_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q       <= LW'(wma_pkg::WINDOW_LENGTH_RESET);
      alpha_q      <= ALPHA_W'(AlphaReset);
      alpha_pend_q <= 1'b0;
    end else begin
      wlen_q       <= wlen_d;
      alpha_q      <= alpha_d;
      alpha_pend_q <= alpha_pend_d;
    end
  end

  // Smoothing factor divider: (2 << F) / (N + 1).
  wma_div #(
    .NW (ANUM_W),
    .DW (LW + 1)
  ) u_alpha_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_wr),
    .num_i   (ANUM_W'(2) << F),
    .den_i   (alpha_den),
    .quot_o  (alpha_quot),
    .stat_o  (alpha_stat)
  );

  // Front: accept and classify samples.
  wma_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_data_i       (in_data_i),
    .window_length_i (wlen_q),
    .cfg_busy_i      (alpha_pend_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_entry_o    (push_entry)
  );

  // Queue between front and back.
  wma_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back: accumulate and emit records.
  wma_back #(
    .EMA_FRACTION_BITS (EMA_FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .alpha_i      (alpha_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

### hw/rtl/wma_div.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle, result held until restart.
// ----------------------------------------------------------------------------
`default_nettype none

module wma_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [NW-1:0]       num_i,
  input  wire logic [DW-1:0]       den_i,
  output logic      [NW-1:0]       quot_o,
  output wma_pkg::div_stat_t       stat_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d;
  logic [NW-1:0] quot_q, quot_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    rem_sh  = {rem_q, num_q[NW-1]};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // Sequencing of the iterations.
  always_comb begin
    num_d  = num_q;
    quot_d = quot_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      num_d  = {num_q[NW-2:0], 1'b0};
      quot_d = {quot_q[NW-2:0], ge};
      rem_d  = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

### hw/rtl/wma_queue.sv
// ----------------------------------------------------------------------------
// Sample queue
// Short register FIFO that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wma_queue #(
  parameter int unsigned DEPTH = wma_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire wma_pkg::q_entry_t push_entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   head_valid_o,
  output wma_pkg::q_entry_t      head_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  wma_pkg::q_entry_t entry_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == CW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wma_front.sv
// ----------------------------------------------------------------------------
// Aggregator front end
// Accepts samples, tracks the position in the window and tags each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module wma_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire wma_pkg::in_t                  in_data_i,
  input  wire logic [wma_pkg::WLEN_W-1:0]    window_length_i,
  input  wire logic                          cfg_busy_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output wma_pkg::q_entry_t                  push_entry_o
);

  localparam int unsigned WLEN_W = wma_pkg::WLEN_W;

  logic [WLEN_W-1:0] idx_q, idx_d;
  logic [WLEN_W:0]   count;
  logic [WLEN_W:0]   eff_len;
  logic              last;

  // Hold off while the queue is full or the smoothing factor is recomputed.
  assign in_stall_o = q_full_i || cfg_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // A zero length behaves as a length of one.
  assign eff_len = (window_length_i == '0) ? (WLEN_W+1)'(1) : {1'b0, window_length_i};
  assign count   = {1'b0, idx_q} + (WLEN_W+1)'(1);
  assign last    = (count >= eff_len);

  always_comb begin
    push_entry_o.data  = in_data_i;
    push_entry_o.first = (idx_q == '0);
    push_entry_o.last  = last;
    push_entry_o.count = count[WLEN_W-1:0];
  end

  // Position within the current window.
  always_comb begin
    idx_d = idx_q;
    if (push_o) begin
      idx_d = last ? '0 : count[WLEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wma_back.sv
// ----------------------------------------------------------------------------
// Aggregator back end
// Runs the EMA and the window accumulators and forms the output record.
// ----------------------------------------------------------------------------
`default_nettype none

module wma_back #(
  parameter int unsigned EMA_FRACTION_BITS = wma_pkg::EMA_FRACTION_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [EMA_FRACTION_BITS:0]     alpha_i,
  input  wire logic                           head_valid_i,
  input  wire wma_pkg::q_entry_t              head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output wma_pkg::out_t                       out_data_o
);

  localparam int unsigned F       = EMA_FRACTION_BITS;
  localparam int unsigned SW      = wma_pkg::SAMPLE_W;
  localparam int unsigned TW      = wma_pkg::TIME_W;
  localparam int unsigned FW      = wma_pkg::FLAGS_W;
  localparam int unsigned LW      = wma_pkg::WLEN_W;
  localparam int unsigned MW      = wma_pkg::MEM_SUM_W;
  localparam int unsigned EW      = SW + F;
  localparam int unsigned PROD_W  = (F + 2) + (EW + 1);
  localparam logic [EW:0] HALF    = (EW+1)'(1) << (F - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0] state_q, state_d;

  // Sample held between the pop and the accumulate cycle.
  wma_pkg::q_entry_t item_q;
  logic signed [PROD_W-1:0] prod_q;

  // Window accumulators.
  logic [EW-1:0] ema_q, ema_d;
  logic [TW-1:0] time_max_q, time_max_d;
  logic [MW-1:0] mem_sum_q, mem_sum_d;
  logic [FW-1:0] cpu_flags_q, cpu_flags_d;
  logic [FW-1:0] mem_flags_q, mem_flags_d;

  logic          out_valid_q, out_valid_d;
  wma_pkg::out_t out_q;

  logic signed [EW:0]       diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] ema_sum;
  logic [EW-1:0]            x_item;
  logic [EW:0]              ema_rnd;
  logic                     out_free;
  logic                     load_out;

  logic                     div_start;
  logic [MW-1:0]            div_quot;
  wma_pkg::div_stat_t       div_stat;

  // Weighted step towards the new sample: alpha * (x - ema).
  always_comb begin
    diff = $signed({1'b0, head_i.data.cpu_sample, {F{1'b0}}}) - $signed({1'b0, ema_q});
    prod = $signed({1'b0, alpha_i}) * diff;
  end

  // EMA update, floor division by 2^F through the arithmetic shift.
  assign x_item  = {item_q.data.cpu_sample, {F{1'b0}}};
  assign ema_sum = $signed({{(PROD_W-EW){1'b0}}, ema_q}) + (prod_q >>> F);
  assign ema_rnd = {1'b0, ema_q} + HALF;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_DIV) && div_stat.done && out_free;
  assign pop_o    = (state_q == ST_IDLE) && head_valid_i;

  // Sequencer for one sample and the window close.
  always_comb begin
    state_d     = state_q;
    ema_d       = ema_q;
    time_max_d  = time_max_q;
    mem_sum_d   = mem_sum_q;
    cpu_flags_d = cpu_flags_q;
    mem_flags_d = mem_flags_q;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        ema_d       = item_q.first ? x_item : ema_sum[EW-1:0];
        time_max_d  = (item_q.data.sample_time > time_max_q) ? item_q.data.sample_time
                                                             : time_max_q;
        mem_sum_d   = mem_sum_q + MW'(item_q.data.mem_sample);
        cpu_flags_d = cpu_flags_q | item_q.data.cpu_state_bits;
        mem_flags_d = mem_flags_q | item_q.data.mem_state_bits;
        if (item_q.last) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d   = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (load_out) begin
          ema_d       = '0;
          time_max_d  = '0;
          mem_sum_d   = '0;
          cpu_flags_d = '0;
          mem_flags_d = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ema_q       <= '0;
      time_max_q  <= '0;
      mem_sum_q   <= '0;
      cpu_flags_q <= '0;
      mem_flags_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ema_q       <= ema_d;
      time_max_q  <= time_max_d;
      mem_sum_q   <= mem_sum_d;
      cpu_flags_q <= cpu_flags_d;
      mem_flags_q <= mem_flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
      prod_q <= prod;
    end
    if (load_out) begin
      out_q.latest_time     <= time_max_q;
      out_q.cpu_smoothed    <= ema_rnd[F+SW-1:F];
      out_q.mem_mean        <= div_quot[SW-1:0];
      out_q.cpu_state_union <= cpu_flags_q;
      out_q.mem_state_union <= mem_flags_q;
    end
  end

  // Mean of the memory samples: sum over the true sample count.
  wma_div #(
    .NW (MW),
    .DW (LW)
  ) u_mean_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mem_sum_d),
    .den_i   (item_q.count),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hw/rtl/wma_checker.sv
// ----------------------------------------------------------------------------
// Window metric aggregator checker
// Port-level properties of the aggregator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_metric_aggregator_assert.svh"

module wma_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_stall_o,
  input  wire logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  input  wire wma_pkg::out_t                    out_data_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic                             pready
);

  // A stalled record stays valid and unchanged.
  `WMA_ASSERT(a_out_hold,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o),
              "stalled output record changed")

  // The configuration port never inserts wait states.
  `WMA_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

  // A length write holds off input while the smoothing factor is recomputed.
  `WMA_ASSERT(a_cfg_stall, psel && penable && pwrite && pready |=> in_stall_o,
              "input accepted during factor update")

  // No record is presented while reset is applied.
  `WMA_ASSERT_ALWAYS(a_rst_out, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind window_metric_aggregator wma_checker u_wma_checker (.*);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window metric aggregator testbench
// Drives metric samples through the valid/stall input channel and programmes
// the window length over APB. A behavioural predictor folds every accepted
// sample into its own window state and queues the record it expects. Each
// record leaving the output channel is compared field by field with the
// oldest queued record. Directed tests cover the reset length, the field
// extremes, a zero length and length changes part-way through a window. A
// back-pressure test and a long randomised run with many window lengths
// follow. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_top;

  // Widths and constants taken from the package.
  localparam int unsigned WLEN_W              = wma_pkg::WLEN_W;
  localparam int unsigned MEM_SUM_W           = wma_pkg::MEM_SUM_W;
  localparam int unsigned TIME_W              = wma_pkg::TIME_W;
  localparam int unsigned FLAGS_W             = wma_pkg::FLAGS_W;
  localparam int unsigned SAMPLE_W            = wma_pkg::SAMPLE_W;
  localparam int unsigned APB_ADDR_W          = wma_pkg::APB_ADDR_W;
  localparam int unsigned APB_DATA_W          = wma_pkg::APB_DATA_W;
  localparam int unsigned WINDOW_LENGTH_RESET = wma_pkg::WINDOW_LENGTH_RESET;

  // Timing and run size.
  localparam int unsigned FRAC_BITS     = wma_pkg::EMA_FRACTION_BITS_DEF;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 1020;
  localparam int unsigned TIMEOUT_NS    = 10000000;

  // Register map.
  localparam logic [APB_ADDR_W-1:0] WINDOW_LENGTH_ADDR = '0;

  // DUT signals.
  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  wma_pkg::in_t          in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  wma_pkg::out_t         out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state: a copy of the block's window accumulators.
  logic [WLEN_W-1:0]    win_len;
  logic [WLEN_W-1:0]    taken;
  logic [63:0]          ema_q;
  logic [63:0]          alpha;
  logic [MEM_SUM_W-1:0] mem_acc;
  logic [TIME_W-1:0]    time_peak;
  logic [FLAGS_W-1:0]   cpu_or;
  logic [FLAGS_W-1:0]   mem_or;

  // Records predicted but not yet seen on the output channel.
  wma_pkg::out_t pending_records[$];

  int unsigned mismatches;
  int unsigned samples_sent;
  int unsigned records_checked;
  int unsigned length_settings;
  int unsigned hold_cycles;
  bit          quiet;

  window_metric_aggregator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #(TIMEOUT_NS);
    $display("window_metric_aggregator: mismatch");
    $finish;
  end

  // Receiver: stalls at random, or for a counted stretch when one is requested.
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 10);
    end
  end

  // Compares one field and counts a mismatch.
  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Checks each record transaction against the oldest predicted record.
  always @(posedge clk_i) begin : check_records
    wma_pkg::out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_records.size() == 0) begin
        $error("record transaction with no record expected");
        mismatches++;
      end else begin
        want = pending_records.pop_front();
        compare_field("latest_time", want.latest_time, out_data_o.latest_time);
        compare_field("cpu_smoothed", 64'(want.cpu_smoothed), 64'(out_data_o.cpu_smoothed));
        compare_field("mem_mean", 64'(want.mem_mean), 64'(out_data_o.mem_mean));
        compare_field("cpu_state_union", 64'(want.cpu_state_union),
                      64'(out_data_o.cpu_state_union));
        compare_field("mem_state_union", 64'(want.mem_state_union),
                      64'(out_data_o.mem_state_union));
        records_checked++;
      end
    end
  end

  // A zero length behaves as a length of one.
  function automatic logic [63:0] effective_length();
    return (win_len == '0) ? 64'd1 : 64'(win_len);
  endfunction

  // Clears the window accumulators of the predictor.
  function automatic void clear_window();
    taken     = '0;
    ema_q     = '0;
    mem_acc   = '0;
    time_peak = '0;
    cpu_or    = '0;
    mem_or    = '0;
  endfunction

  // Updates the length register copy and its smoothing factor.
  function automatic void load_length(input logic [WLEN_W-1:0] len);
    win_len = len;
    alpha   = (64'd2 << FRAC_BITS) / (effective_length() + 64'd1);
  endfunction

  // Folds one accepted sample into the window and queues a record when it closes.
  function automatic void fold_sample(input wma_pkg::in_t s);
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] a;
    logic [63:0] rounded;
    logic [63:0] cnt;
    logic [MEM_SUM_W-1:0] mean;
    wma_pkg::out_t rec;
    one = 64'd1 << FRAC_BITS;
    x   = 64'(s.cpu_sample) << FRAC_BITS;
    if (taken == '0) begin
      ema_q = x;
    end else begin
      a = (alpha > one) ? one : alpha;
      ema_q = (a * x + (one - a) * ema_q) >> FRAC_BITS;
    end
    if (s.sample_time > time_peak) time_peak = s.sample_time;
    mem_acc = mem_acc + MEM_SUM_W'(s.mem_sample);
    cpu_or  = cpu_or | s.cpu_state_bits;
    mem_or  = mem_or | s.mem_state_bits;
    cnt = 64'(taken) + 64'd1;
    if (cnt < effective_length()) begin
      taken = cnt[WLEN_W-1:0];
    end else begin
      rounded = (ema_q + (one >> 1)) >> FRAC_BITS;
      mean    = mem_acc / cnt[MEM_SUM_W-1:0];
      rec.latest_time     = time_peak;
      rec.cpu_smoothed    = rounded[SAMPLE_W-1:0];
      rec.mem_mean        = mean[SAMPLE_W-1:0];
      rec.cpu_state_union = cpu_or;
      rec.mem_state_union = mem_or;
      pending_records.push_back(rec);
      clear_window();
    end
  endfunction

  // Builds a sample from its fields.
  function automatic wma_pkg::in_t make_sample(input logic [TIME_W-1:0] t,
                                               input logic [15:0] cpu,
                                               input logic [15:0] mem,
                                               input logic [15:0] cflags,
                                               input logic [15:0] mflags);
    wma_pkg::in_t s;
    s.sample_time    = t;
    s.cpu_sample     = cpu;
    s.mem_sample     = mem;
    s.cpu_state_bits = cflags;
    s.mem_state_bits = mflags;
    return s;
  endfunction

  // Random sample with occasional extremes and sparse flag words.
  function automatic wma_pkg::in_t rand_sample();
    wma_pkg::in_t s;
    s.sample_time    = {$urandom, $urandom};
    s.cpu_sample     = 16'($urandom);
    s.mem_sample     = 16'($urandom);
    s.cpu_state_bits = $urandom_range(1) ? 16'($urandom) : 16'(16'd1 << $urandom_range(15));
    s.mem_state_bits = $urandom_range(1) ? 16'($urandom) : 16'(16'd1 << $urandom_range(15));
    case ($urandom_range(7))
      0: begin
        s.sample_time = '1;
        s.cpu_sample  = '1;
        s.mem_sample  = '1;
      end
      1: begin
        s.sample_time = '0;
        s.cpu_sample  = '0;
        s.mem_sample  = '0;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Offers one sample and waits until the block takes the transaction.
  task automatic send_sample(input wma_pkg::in_t s);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    fold_sample(s);
    samples_sent++;
  endtask

  // Drops valid and waits until every record is out and the block has settled.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer to the window length register.
  task automatic apb_access(input bit write, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= WINDOW_LENGTH_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reads the length register and compares it with the predictor's copy.
  task automatic check_length_readback();
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    compare_field("window_length", 64'(win_len), 64'(rdata[WLEN_W-1:0]));
  endtask

  // Writes a new window length once the block is idle; upper data bits are junk.
  task automatic set_window_length(input logic [WLEN_W-1:0] len);
    logic [APB_DATA_W-1:0] rdata;
    wait_drained();
    apb_access(1'b1, {16'($urandom), len}, rdata);
    load_length(len);
    length_settings++;
    check_length_readback();
  endtask

  // Reset length of 60 and its smoothing factor, over one full window.
  task automatic test_reset_window();
    check_length_readback();
    repeat (WINDOW_LENGTH_RESET) send_sample(rand_sample());
  endtask

  // Field extremes and bit patterns in windows of two.
  task automatic test_field_extremes();
    set_window_length(16'd2);
    send_sample(make_sample('1, '1, '1, '1, '1));
    send_sample(make_sample('0, '0, '0, '0, '0));
    send_sample(make_sample('0, '0, '0, '0, '0));
    send_sample(make_sample('1, '1, '1, '1, '1));
    send_sample(make_sample(64'h8000_0000_0000_0000, 16'h8000, 16'h8000, 16'hAAAA, 16'h5555));
    send_sample(make_sample(64'h7FFF_FFFF_FFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h5555, 16'hAAAA));
    send_sample(make_sample(64'd1, 16'd1, 16'd1, 16'h0001, 16'h8000));
    send_sample(make_sample(64'd1, 16'd0, 16'd2, 16'h8000, 16'h0001));
  endtask

  // A zero length closes a window on every sample.
  task automatic test_zero_length();
    set_window_length(16'd0);
    repeat (4) send_sample(rand_sample());
  endtask

  // Length changes part-way through a window: shrinking below the count and growing.
  task automatic test_length_change();
    set_window_length(16'hFFFF);
    repeat (6) send_sample(rand_sample());
    set_window_length(16'd4);
    send_sample(rand_sample());
    repeat (2) send_sample(rand_sample());
    set_window_length(16'd8);
    repeat (6) send_sample(rand_sample());
  endtask

  // Receiver holds off for a long stretch while samples keep coming.
  task automatic test_back_pressure();
    set_window_length(16'd1);
    @(posedge clk_i);
    hold_cycles = HOLD_CYCLES;
    repeat (40) send_sample(rand_sample());
  endtask

  // Random samples over many window lengths, with one phase free of idling.
  task automatic test_random_windows();
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    logic [WLEN_W-1:0] len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 5) len = 16'd0;
      else if (pick < 10) len = 16'hFFFF;
      else if (pick < 15) len = WLEN_W'(WINDOW_LENGTH_RESET);
      else if (pick < 30) len = 16'($urandom_range(80, 13));
      else len = 16'($urandom_range(12, 1));
      if (len == 16'd0) burst = $urandom_range(6, 1);
      else if (len > 16'd80) burst = $urandom_range(24, 1);
      else burst = $urandom_range(3 * int'(len), 1);
      set_window_length(len);
      quiet = (sent >= 400 && sent < 600);
      repeat (burst) begin
        send_sample(rand_sample());
        sent++;
      end
      quiet = 1'b0;
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    mismatches      = 0;
    samples_sent    = 0;
    records_checked = 0;
    length_settings = 0;
    hold_cycles     = 0;
    quiet           = 1'b0;
    load_length(WLEN_W'(WINDOW_LENGTH_RESET));
    clear_window();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_window();
    test_field_extremes();
    test_zero_length();
    test_length_change();
    test_back_pressure();
    test_random_windows();
    wait_drained();

    $display("Covered %0d samples and %0d window records over %0d length settings,",
             samples_sent, records_checked, length_settings);
    $display("including zero, one, the reset length, 65535 and mid-window changes.");
    if (mismatches == 0) begin
      $display("window_metric_aggregator: match");
    end else begin
      $display("window_metric_aggregator: mismatch");
    end
    $finish;
  end

endmodule
